FILE: src/cbc_pkg.sv
// Shared types and constants for the cartridge bank controller.
package cbc_pkg;

    localparam int RAM_BANK_COUNT = 16;

    localparam int ADDR_W     = 16;
    localparam int DATA_W     = 8;
    localparam int ROM_BANK_W = 9;
    localparam int RAM_BANK_W = 4;
    localparam int CTRL_W     = 3;
    localparam int LOW_W      = 8;
    localparam int HIGH_W     = 2;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 16;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // controller kinds
    localparam logic [CTRL_W-1:0] CTRL_NONE  = 3'd0;
    localparam logic [CTRL_W-1:0] CTRL_TYPE1 = 3'd1;
    localparam logic [CTRL_W-1:0] CTRL_TYPE2 = 3'd2;
    localparam logic [CTRL_W-1:0] CTRL_TYPE3 = 3'd3;
    localparam logic [CTRL_W-1:0] CTRL_TYPE5 = 3'd5;

    // bus regions by address bits [15:13]
    localparam logic [2:0] REGION_RAM_ENABLE = 3'b000;
    localparam logic [2:0] REGION_ROM_BANK   = 3'b001;
    localparam logic [2:0] REGION_RAM_BANK   = 3'b010;
    localparam logic [2:0] REGION_MODE       = 3'b011;
    localparam logic [2:0] REGION_EXT_RAM    = 3'b101;

    localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;

    // register word index
    localparam logic REG_CONTROLLER_TYPE = 1'b0;

    typedef struct packed {
        logic [ROM_BANK_W-1:0] rom_bank;
        logic [RAM_BANK_W-1:0] ram_bank;
        logic                  ram_enabled;
        logic                  ram_write_ok;
        logic                  banking_mode;
    } cbc_result_t;

    // type 1 bank: high*32 + low, bumped when the low five bits are zero
    function automatic logic [ROM_BANK_W-1:0] type1_bank(
        input logic [HIGH_W-1:0] high,
        input logic [LOW_W-1:0]  low
    );
        logic [10:0] b;
        begin
            b = 11'({high, 5'd0}) + 11'(low);
            if (b[4:0] == 5'd0)
            begin
                b = b + 11'd1;
            end
            return b[ROM_BANK_W-1:0];
        end
    endfunction

endpackage

FILE: src/cbc_apb_regs.sv
// APB configuration register holding the controller type.
module cbc_apb_regs
    import cbc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [CTRL_W-1:0]     controller_type
);

    logic [CTRL_W-1:0] ctrl_type_reg;
    logic              wr_en;
    logic              hit;

    assign pready = 1'b1;
    assign hit    = (paddr[APB_ADDR_W-1] == REG_CONTROLLER_TYPE);
    assign wr_en  = psel && penable && pwrite && pready && hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_type_reg <= CTRL_NONE;
        end
        else if (wr_en)
        begin
            ctrl_type_reg <= pwdata[CTRL_W-1:0];
        end
    end

    assign prdata          = hit ? APB_DATA_W'(ctrl_type_reg) : '0;
    assign controller_type = ctrl_type_reg;

endmodule

FILE: src/cbc_bank_core.sv
// Bank state registers and the per-write update logic.
module cbc_bank_core
    import cbc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [CTRL_W-1:0] controller_type,
    input  logic [ADDR_W-1:0] bus_address,
    input  logic [DATA_W-1:0] bus_data,
    output cbc_result_t       result
);

    logic                  ram_enable_reg, ram_enable_next;
    logic [LOW_W-1:0]      low_reg, low_next;
    logic [HIGH_W-1:0]     high_reg, high_next;
    logic [ROM_BANK_W-1:0] rom_bank_reg, rom_bank_next;
    logic [RAM_BANK_W-1:0] ram_bank_reg, ram_bank_next;
    logic                  mode_reg, mode_next;
    logic                  write_ok;
    logic [2:0]            region;
    logic [RAM_BANK_W-1:0] ram_sel;

    assign region  = bus_address[ADDR_W-1:ADDR_W-3];
    assign ram_sel = RAM_BANK_W'(5'(bus_data[3:0]) % 5'(RAM_BANK_COUNT));

    always_comb
    begin
        ram_enable_next = ram_enable_reg;
        low_next        = low_reg;
        high_next       = high_reg;
        rom_bank_next   = rom_bank_reg;
        ram_bank_next   = ram_bank_reg;
        mode_next       = mode_reg;
        write_ok        = 1'b0;
        case (region)
            REGION_RAM_ENABLE:
            begin
                ram_enable_next = (bus_data[3:0] == RAM_ENABLE_KEY);
            end
            REGION_ROM_BANK:
            begin
                if (controller_type != CTRL_NONE)
                begin
                    if (controller_type == CTRL_TYPE3)
                    begin
                        rom_bank_next = ROM_BANK_W'(bus_data[6:0]);
                    end
                    else if (controller_type == CTRL_TYPE5 && !bus_address[12])
                    begin
                        low_next = bus_data;
                    end
                    else if (controller_type == CTRL_TYPE5)
                    begin
                        high_next = HIGH_W'(bus_data[0]);
                    end
                    else
                    begin
                        low_next = LOW_W'(bus_data[4:0]);
                    end

                    if (controller_type == CTRL_TYPE1)
                    begin
                        rom_bank_next = type1_bank(high_next, low_next);
                    end
                    else if (controller_type == CTRL_TYPE2)
                    begin
                        rom_bank_next = ROM_BANK_W'(low_next);
                    end
                    else if (controller_type == CTRL_TYPE5)
                    begin
                        rom_bank_next = {high_next[0], low_next};
                    end
                end
            end
            REGION_RAM_BANK:
            begin
                if (controller_type == CTRL_TYPE1 && !mode_reg)
                begin
                    high_next     = bus_data[1:0];
                    rom_bank_next = type1_bank(bus_data[1:0], low_reg);
                    ram_bank_next = '0;
                end
                else if (controller_type != CTRL_NONE)
                begin
                    if (controller_type != CTRL_TYPE3 || bus_data <= 8'd3)
                    begin
                        ram_bank_next = ram_sel;
                    end
                end
            end
            REGION_MODE:
            begin
                if (controller_type == CTRL_TYPE1)
                begin
                    mode_next = bus_data[0];
                end
            end
            REGION_EXT_RAM:
            begin
                write_ok = ram_enable_reg;
            end
            default:
            begin
                write_ok = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ram_enable_reg <= 1'b0;
            low_reg        <= '0;
            high_reg       <= '0;
            rom_bank_reg   <= ROM_BANK_W'(1);
            ram_bank_reg   <= '0;
            mode_reg       <= 1'b0;
        end
        else if (accept)
        begin
            ram_enable_reg <= ram_enable_next;
            low_reg        <= low_next;
            high_reg       <= high_next;
            rom_bank_reg   <= rom_bank_next;
            ram_bank_reg   <= ram_bank_next;
            mode_reg       <= mode_next;
        end
    end

    assign result.rom_bank     = rom_bank_next;
    assign result.ram_bank     = ram_bank_next;
    assign result.ram_enabled  = ram_enable_next;
    assign result.ram_write_ok = write_ok;
    assign result.banking_mode = mode_next;

endmodule

FILE: src/cbc_out_buffer.sv
// Result register with a skid stage so one more request is taken while the sink stalls.
module cbc_out_buffer
    import cbc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  cbc_result_t in_result,
    output logic        out_valid,
    input  logic        out_ready,
    output cbc_result_t out_result
);

    logic        out_valid_reg;
    logic        skid_valid_reg;
    cbc_result_t out_reg;
    cbc_result_t skid_reg;
    logic        accept;
    logic        pop;

    assign in_ready = !skid_valid_reg;
    assign accept   = in_valid && in_ready;
    assign pop      = out_valid_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (accept)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (accept)
        begin
            if (!out_valid_reg || pop)
            begin
                out_reg <= in_result;
            end
            else
            begin
                skid_reg <= in_result;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

endmodule

FILE: src/cartridge_bank_controller.sv
// Top level of the cartridge bank controller.
//
// Usage:
//   s_axis carries one CPU bus write per request; s_axis_tdata holds
//   bus_address in [15:0] and bus_data in [23:16].
//   m_axis returns one result per request with the bank state after the write.
//   The APB port holds controller_type at byte address 0 (0 none, 1, 2, 3, 5).
//   Change it only while no request is in flight.
// An accepted request's result is registered in the output or skid register.
// Throughput: one request per cycle while s_axis_tready is high; the bank update
//   is a single decode and mux level between the state and result registers.
// Reset: ROM bank 1, RAM bank 0, RAM disabled, mode 0, controller type none;
//   no result is pending.
// Stall: a two-entry result buffer (output register plus skid) lets one more
//   request in while m_axis_tready is low; s_axis_tready drops once both
//   entries are full and rises again when the sink takes a result.
module cartridge_bank_controller
    import cbc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [15:0] bus_address, [23:16] bus_data
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata    // [8:0] rom_bank, [12:9] ram_bank,
                                                   // [13] ram_enabled, [14] ram_write_ok,
                                                   // [15] banking_mode
);

    logic [CTRL_W-1:0] controller_type;
    logic              accept;
    cbc_result_t       core_result;
    cbc_result_t       out_result;

    assign accept = s_axis_tvalid && s_axis_tready;

    cbc_apb_regs u_regs (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .controller_type (controller_type)
    );

    cbc_bank_core u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .controller_type (controller_type),
        .bus_address     (s_axis_tdata[15:0]),
        .bus_data        (s_axis_tdata[23:16]),
        .result          (core_result)
    );

    cbc_out_buffer u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_result  (core_result),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (out_result)
    );

    assign m_axis_tdata = {out_result.banking_mode, out_result.ram_write_ok,
                           out_result.ram_enabled, out_result.ram_bank,
                           out_result.rom_bank};

endmodule

FILE: test/bank_scoreboard_pkg.sv
// Scoreboard for the cartridge bank controller: bank state predictor and result checker.
package bank_scoreboard_pkg;

    import cbc_pkg::*;

    class bank_scoreboard;

        logic [CTRL_W-1:0]     ctrl_kind;
        logic                  ram_on;
        logic [LOW_W-1:0]      low_part;
        logic [HIGH_W-1:0]     high_part;
        logic [ROM_BANK_W-1:0] rom_sel;
        logic [RAM_BANK_W-1:0] ram_sel;
        logic                  mode;

        cbc_result_t expected_banks[$];
        int errors;
        int requests;
        int checked;

        function new();
            ctrl_kind = CTRL_NONE;
            ram_on    = 1'b0;
            low_part  = '0;
            high_part = '0;
            rom_sel   = ROM_BANK_W'(1);
            ram_sel   = '0;
            mode      = 1'b0;
            errors    = 0;
            requests  = 0;
            checked   = 0;
        endfunction

        function void set_kind(logic [CTRL_W-1:0] kind);
            ctrl_kind = kind;
        endfunction

        function int pending();
            return expected_banks.size();
        endfunction

        // high*32 + low, stepped up by one when the low five bits are zero
        function logic [ROM_BANK_W-1:0] joined_bank();
            logic [10:0] sum;
            sum = {4'b0, high_part, 5'b0} + {3'b0, low_part};
            if (sum[4:0] == 5'd0)
            begin
                sum = sum + 11'd1;
            end
            return sum[ROM_BANK_W-1:0];
        endfunction

        function void note_request(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
            cbc_result_t next;
            logic        write_ok;
            write_ok = 1'b0;
            case (addr[15:13])
                REGION_RAM_ENABLE:
                begin
                    ram_on = (data[3:0] == RAM_ENABLE_KEY);
                end
                REGION_ROM_BANK:
                begin
                    if (ctrl_kind != CTRL_NONE)
                    begin
                        if (ctrl_kind == CTRL_TYPE3)
                            rom_sel = {2'b0, data[6:0]};
                        else if (ctrl_kind == CTRL_TYPE5 && !addr[12])
                            low_part = data;
                        else if (ctrl_kind == CTRL_TYPE5)
                            high_part = {1'b0, data[0]};
                        else
                            low_part = {3'b0, data[4:0]};

                        if (ctrl_kind == CTRL_TYPE1)
                            rom_sel = joined_bank();
                        else if (ctrl_kind == CTRL_TYPE2)
                            rom_sel = {1'b0, low_part};
                        else if (ctrl_kind == CTRL_TYPE5)
                            rom_sel = {high_part[0], low_part};
                    end
                end
                REGION_RAM_BANK:
                begin
                    if (ctrl_kind == CTRL_TYPE1 && !mode)
                    begin
                        high_part = data[1:0];
                        rom_sel   = joined_bank();
                        ram_sel   = '0;
                    end
                    else if (ctrl_kind != CTRL_NONE)
                    begin
                        if (ctrl_kind != CTRL_TYPE3 || data <= 8'd3)
                            ram_sel = data[3:0];
                    end
                end
                REGION_MODE:
                begin
                    if (ctrl_kind == CTRL_TYPE1)
                        mode = data[0];
                end
                REGION_EXT_RAM:
                begin
                    write_ok = ram_on;
                end
                default:
                begin
                end
            endcase
            next.rom_bank     = rom_sel;
            next.ram_bank     = ram_sel;
            next.ram_enabled  = ram_on;
            next.ram_write_ok = write_ok;
            next.banking_mode = mode;
            expected_banks.push_back(next);
            requests++;
        endfunction

        function void compare(string name, logic [ROM_BANK_W-1:0] want,
                              logic [ROM_BANK_W-1:0] got);
            if (got !== want)
            begin
                errors++;
                $error("%s mismatch: expected %0d, got %0d", name, want, got);
            end
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] word);
            cbc_result_t want;
            if (expected_banks.size() == 0)
            begin
                errors++;
                $error("result %h arrived with no request outstanding", word);
                return;
            end
            want = expected_banks.pop_front();
            checked++;
            compare("rom_bank", want.rom_bank, word[8:0]);
            compare("ram_bank", 9'(want.ram_bank), 9'(word[12:9]));
            compare("ram_enabled", 9'(want.ram_enabled), 9'(word[13]));
            compare("ram_write_ok", 9'(want.ram_write_ok), 9'(word[14]));
            compare("banking_mode", 9'(want.banking_mode), 9'(word[15]));
        endfunction

    endclass

endpackage

FILE: test/tb_top.sv
// Testbench top for the cartridge bank controller: stimulus, flow control and final check.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import cbc_pkg::*;
    import bank_scoreboard_pkg::*;

    localparam logic [CTRL_W-1:0] CTRL_UNUSED4 = 3'd4;
    localparam logic [CTRL_W-1:0] CTRL_UNUSED6 = 3'd6;
    localparam logic [CTRL_W-1:0] CTRL_UNUSED7 = 3'd7;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 50;
    localparam logic [CTRL_W-1:0] PHASE_KINDS [PHASES] = '{
        CTRL_TYPE1, CTRL_TYPE5, CTRL_TYPE3, CTRL_TYPE2, CTRL_NONE, CTRL_UNUSED4,
        CTRL_TYPE1, CTRL_UNUSED6, CTRL_UNUSED7, CTRL_TYPE5, CTRL_TYPE1, CTRL_TYPE3
    };

    logic                   clk;
    logic                   rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_ADDR_W-1:0]  paddr;
    logic [APB_DATA_W-1:0]  pwdata;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    bank_scoreboard sb = new();
    int burst_left;
    int settings_used;
    bit long_hold_req;

    cartridge_bank_controller DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // sink: own stall pattern plus one long hold on request
    initial
    begin
        int hold_left;
        int mode_left;
        int stall_mode;
        hold_left = 0;
        mode_left = 0;
        stall_mode = 0;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left = 300;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(8, 64);
                end
                mode_left--;
                case (stall_mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= 1'($urandom_range(0, 1));
                    2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: m_axis_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    task automatic apb_access(input bit wr, input logic [APB_ADDR_W-1:0] addr,
                              input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // only while idle: drain, let the pipe settle, then program and read back
    task automatic set_controller(input logic [CTRL_W-1:0] kind);
        logic [APB_DATA_W-1:0] rd;
        logic [APB_ADDR_W-1:0] reg_addr;
        reg_addr = {REG_CONTROLLER_TYPE, 2'b00};
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
        apb_access(1'b1, reg_addr, {29'($urandom), kind}, rd);
        sb.set_kind(kind);
        @(posedge clk);
        apb_access(1'b0, reg_addr, '0, rd);
        if (rd[CTRL_W-1:0] !== kind)
        begin
            sb.errors++;
            $error("controller_type mismatch: expected %0d, got %0d", kind, rd[CTRL_W-1:0]);
        end
        settings_used++;
    endtask

    task automatic send_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {data, addr};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_request(addr, data);
        burst_left--;
    endtask

    function automatic logic [DATA_W-1:0] pick_data();
        case ($urandom_range(0, 3))
            0: return 8'($urandom);
            1: return {4'($urandom), RAM_ENABLE_KEY};
            2: return 8'($urandom_range(0, 3));
            default: return {3'($urandom), 5'd0};
        endcase
    endfunction

    function automatic logic [ADDR_W-1:0] pick_address();
        int r;
        logic [2:0] top;
        r = $urandom_range(0, 99);
        if (r < 18)
            return {REGION_RAM_ENABLE, 13'($urandom)};
        else if (r < 43)
            return {REGION_ROM_BANK, 13'($urandom)};
        else if (r < 63)
            return {REGION_RAM_BANK, 13'($urandom)};
        else if (r < 72)
            return {REGION_MODE, 13'($urandom)};
        else if (r < 86)
            return {REGION_EXT_RAM, 13'($urandom)};
        else if (r < 94)
        begin
            // unmapped regions
            top = 3'($urandom_range(4, 7));
            if (top == REGION_EXT_RAM)
                top = top - 3'd1;
            return {top, 13'($urandom)};
        end
        return 16'($urandom);
    endfunction

    initial
    begin
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        rst_n         <= 1'b0;
        burst_left    = 0;
        settings_used = 0;
        long_hold_req = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: enable key, ROM bank zero fixup, mode switch, leftover high part
        set_controller(CTRL_TYPE1);
        send_write(16'h0000, 8'h0A);
        send_write(16'h1FFF, 8'hFA);
        send_write(16'hA000, 8'h55);
        send_write(16'hBFFF, 8'hFF);
        send_write(16'h1000, 8'h0B);
        send_write(16'hA123, 8'h00);
        send_write(16'h2000, 8'h00);
        send_write(16'h3FFF, 8'hFF);
        send_write(16'h4000, 8'h03);
        send_write(16'h2000, 8'h20);
        send_write(16'h6000, 8'h01);
        send_write(16'h5FFF, 8'hFF);
        send_write(16'h7FFF, 8'hFE);
        send_write(16'hFFFF, 8'hFF);
        set_controller(CTRL_TYPE5);
        send_write(16'h2FFF, 8'hFF);
        send_write(16'h3000, 8'h01);
        send_write(16'h4000, 8'h0F);
        set_controller(CTRL_TYPE3);
        send_write(16'h2000, 8'hFF);
        send_write(16'h4000, 8'h03);
        send_write(16'h4000, 8'h04);
        set_controller(CTRL_TYPE2);
        send_write(16'h2000, 8'h00);
        set_controller(CTRL_UNUSED7);
        send_write(16'h2000, 8'h15);
        send_write(16'h4000, 8'h09);
        set_controller(CTRL_NONE);
        send_write(16'h2000, 8'h05);
        send_write(16'h6000, 8'h01);

        for (int p = 0; p < PHASES; p++)
        begin
            set_controller(PHASE_KINDS[p]);
            if (p == 2)
                long_hold_req = 1'b1;
            repeat (PHASE_ITEMS)
                send_write(pick_address(), pick_data());
        end
        s_axis_tvalid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);

        $display("Covered %0d bus writes over %0d controller settings (types 0-7),",
                 sb.requests, settings_used);
        $display("with %0d results compared and %0d mismatches.", sb.checked, sb.errors);
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
src/cbc_pkg.sv
src/cbc_apb_regs.sv
src/cbc_bank_core.sv
src/cbc_out_buffer.sv
src/cartridge_bank_controller.sv
test/bank_scoreboard_pkg.sv
test/tb_top.sv
